>>> hdl/lpmf_pkg.sv
// ============================================================================
// lpmf_pkg - shared types and constants
// Word layouts, status codes and register indexes of the point mask filter.
// ============================================================================
package lpmf_pkg;

    localparam int PT_W    = 24;   // lidar coordinate, mm
    localparam int PIX_W   = 9;    // mask write address
    localparam int GRAY_W  = 8;
    localparam int UV_W    = 16;   // projected pixel
    localparam int CIDX_W  = 4;
    localparam int CVAL_W  = 64;
    localparam int SIZE_W  = 10;   // mask size registers
    localparam int CAM_W   = 42;   // camera coordinate, Q.14 mm
    localparam int ZD_W    = 41;   // positive depth
    localparam int PROD_W  = 40;   // rotation term times coordinate
    localparam int FQ_W    = 24;   // focal length / centre, Q16.8
    localparam int MLO_W   = 21;   // low slice of |num| for the split multiply
    localparam int PP_W    = 45;   // partial product width
    localparam int DIVN_W  = 64;   // dividend f*|num|
    localparam int QK      = 27;   // quotient bits; anything larger saturates

    typedef enum logic [2:0] {
        ST_SELECTED = 3'd0,
        ST_BEHIND   = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_MASK_OFF = 3'd3,
        ST_STORED   = 3'd4
    } status_t;

    localparam logic [CIDX_W-1:0] CFG_ROW_X    = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_ROW_Y    = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_ROW_Z    = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_FOCAL    = 4'd3;
    localparam logic [CIDX_W-1:0] CFG_CENTRE   = 4'd4;
    localparam logic [CIDX_W-1:0] CFG_COLS     = 4'd5;
    localparam logic [CIDX_W-1:0] CFG_ROWS     = 4'd6;
    localparam logic [CIDX_W-1:0] CFG_THRESH   = 4'd7;

    typedef struct packed {
        logic                     kind;
        logic signed [PT_W-1:0]   point_x;
        logic signed [PT_W-1:0]   point_y;
        logic signed [PT_W-1:0]   point_z;
        logic [PIX_W-1:0]         pixel_col;
        logic [PIX_W-1:0]         pixel_row;
        logic [GRAY_W-1:0]        gray;
    } in_word_t;

    typedef struct packed {
        status_t                  status;
        logic signed [UV_W-1:0]   pix_u;
        logic signed [UV_W-1:0]   pix_v;
        logic signed [PT_W-1:0]   out_x;
        logic signed [PT_W-1:0]   out_y;
        logic signed [PT_W-1:0]   out_z;
    } out_word_t;

    typedef struct packed {
        logic [CIDX_W-1:0]        index;
        logic [CVAL_W-1:0]        value;
    } cfg_word_t;

endpackage

>>> hdl/lpmf_chan_if.sv
// ============================================================================
// lpmf_chan_if - valid/ready channel
// One word moves at a rising edge with valid and ready both high.
// ============================================================================
interface lpmf_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/lpmf_ram.sv
// ============================================================================
// lpmf_ram - single port RAM
// One access per cycle; a read returns data on the next edge and holds it.
// ============================================================================
module lpmf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

>>> hdl/lidar_point_mask_projection_filter_top.sv
// ============================================================================
// lidar_point_mask_projection_filter_top - lidar point mask filter
// Rigid transform, pinhole projection and binary mask lookup of lidar points.
// ============================================================================
// Usage
//   cfg     : register writes (index, value), always ready. Write only while
//             no word is in flight.
//   points  : input words. kind 0 stores one mask bit (gray > threshold),
//             kind 1 tests one lidar point. Load the whole mask first.
//   results : one word per input word, in order.
// Timing
//   37-stage pipeline; one word per cycle is taken while results drains.
//   The depth comes from the restoring divider, one quotient bit per stage
//   (27 stages), for both image axes in parallel.
//   The mask sits in a single-port RAM that is written and read at one
//   point of the pipeline, so mask writes and point lookups keep their order.
// Reset / stall
//   Reset empties the pipeline and loads the identity transform; the mask
//   contents stay undefined until written. When results stalls, the whole
//   pipeline holds; an empty first stage still takes a word.
// ============================================================================
module lidar_point_mask_projection_filter_top
    import lpmf_pkg::*;
#(
    parameter int MAX_MASK_COLS = 512,
    parameter int MAX_MASK_ROWS = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    lpmf_chan_if.sink     cfg,
    lpmf_chan_if.sink     points,
    lpmf_chan_if.source   results
);

    localparam int DEPTH  = MAX_MASK_COLS * MAX_MASK_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = ($clog2(MAX_MASK_COLS + 1) > SIZE_W) ?
                            $clog2(MAX_MASK_COLS + 1) : SIZE_W;
    localparam int RW     = ($clog2(MAX_MASK_ROWS + 1) > SIZE_W) ?
                            $clog2(MAX_MASK_ROWS + 1) : SIZE_W;

    localparam int S_SUM  = 1;
    localparam int S_MUL  = 2;
    localparam int S_ADD  = 3;
    localparam int S_OVF  = 4;
    localparam int S_DIV  = 5;
    localparam int S_SC   = S_DIV + QK;
    localparam int S_RND  = S_SC + 1;
    localparam int S_ADDR = S_RND + 1;
    localparam int S_HOLD = S_ADDR + 1;
    localparam int S_OUT  = S_HOLD + 1;
    localparam int NSTG   = S_OUT + 1;

    typedef struct packed {
        logic                       kind;
        logic signed [PT_W-1:0]     x;
        logic signed [PT_W-1:0]     y;
        logic signed [PT_W-1:0]     z;
        logic [8:0][PROD_W-1:0]     prod;
        logic                       wr_ok;
        logic                       wr_bit;
        logic [ADDR_W-1:0]          addr;
        logic signed [CAM_W-1:0]    cx;
        logic signed [CAM_W-1:0]    cy;
        logic signed [CAM_W-1:0]    cz;
        logic                       behind;
        logic                       neg_u;
        logic                       neg_v;
        logic [PP_W-1:0]            ml_u;
        logic [PP_W-1:0]            mh_u;
        logic [PP_W-1:0]            ml_v;
        logic [PP_W-1:0]            mh_v;
        logic [ZD_W-1:0]            zd;
        logic [DIVN_W-1:0]          a_u;
        logic [DIVN_W-1:0]          a_v;
        logic                       ovf_u;
        logic                       ovf_v;
        logic [ZD_W-1:0]            r_u;
        logic [ZD_W-1:0]            r_v;
        logic [QK-1:0]              q_u;
        logic [QK-1:0]              q_v;
        logic                       nz_u;
        logic                       nz_v;
        logic signed [31:0]         s_u;
        logic signed [31:0]         s_v;
        logic signed [UV_W-1:0]     pu;
        logic signed [UV_W-1:0]     pv;
        status_t                    status;
        logic                       need_rd;
    } item_t;

    // configuration
    logic [CVAL_W-1:0] row_x_reg, row_y_reg, row_z_reg, focal_reg, centre_reg;
    logic [SIZE_W-1:0] mask_cols_reg, mask_rows_reg;
    logic [GRAY_W-1:0] mask_thr_reg;
    logic [CW-1:0]     cols_eff;
    logic [RW-1:0]     rows_eff;

    item_t             pipe_reg  [NSTG];
    item_t             pipe_next [NSTG];
    logic [NSTG-1:0]   valid_reg;
    logic              en_all;
    logic              ld0;

    logic              ram_en;
    logic              ram_q;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg     <= 64'h4000_0000_0000_0000;
            row_y_reg     <= 64'h0000_4000_0000_0000;
            row_z_reg     <= 64'h0000_0000_4000_0000;
            focal_reg     <= '0;
            centre_reg    <= '0;
            mask_cols_reg <= SIZE_W'(512);
            mask_rows_reg <= SIZE_W'(512);
            mask_thr_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_ROW_X:  row_x_reg     <= cfg.data.value;
                CFG_ROW_Y:  row_y_reg     <= cfg.data.value;
                CFG_ROW_Z:  row_z_reg     <= cfg.data.value;
                CFG_FOCAL:  focal_reg     <= cfg.data.value;
                CFG_CENTRE: centre_reg    <= cfg.data.value;
                CFG_COLS:   mask_cols_reg <= cfg.data.value[SIZE_W-1:0];
                CFG_ROWS:   mask_rows_reg <= cfg.data.value[SIZE_W-1:0];
                CFG_THRESH: mask_thr_reg  <= cfg.data.value[GRAY_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cols_eff = (CW'(mask_cols_reg) > CW'(MAX_MASK_COLS)) ?
                      CW'(MAX_MASK_COLS) : CW'(mask_cols_reg);
    assign rows_eff = (RW'(mask_rows_reg) > RW'(MAX_MASK_ROWS)) ?
                      RW'(MAX_MASK_ROWS) : RW'(mask_rows_reg);

    // ---------------------------------------------------------------- helpers
    function automatic logic [PROD_W-1:0] tmul(logic [15:0] r, logic signed [PT_W-1:0] p);
        logic signed [PROD_W-1:0] m;
        m = $signed(r) * p;
        return m;
    endfunction

    function automatic logic signed [CAM_W-1:0] rsum(logic [PROD_W-1:0] a,
                                                      logic [PROD_W-1:0] b,
                                                      logic [PROD_W-1:0] c,
                                                      logic [15:0] t);
        logic signed [CAM_W-1:0] sa, sb, sc, st;
        sa = $signed(a);
        sb = $signed(b);
        sc = $signed(c);
        st = $signed(t);
        return sa + sb + sc + (st <<< 14);
    endfunction

    // one restoring step: {remainder, quotient}
    function automatic logic [ZD_W+QK-1:0] dstep(logic [ZD_W-1:0] r, logic [QK-1:0] q,
                                                 logic b, logic [ZD_W-1:0] d);
        logic [ZD_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
            return {ZD_W'(t - {1'b0, d}), q[QK-2:0], 1'b1};
        else
            return {t[ZD_W-1:0], q[QK-2:0], 1'b0};
    endfunction

    // floor(f*num/z) + c
    function automatic logic signed [31:0] sfun(logic neg, logic [QK-1:0] q, logic nz,
                                                logic [FQ_W-1:0] c);
        logic signed [31:0] qs, cs, fl;
        qs = $signed({5'd0, q});
        cs = $signed({8'd0, c});
        fl = neg ? (-qs - $signed({31'd0, nz})) : qs;
        return fl + cs;
    endfunction

    // divide by 256, halves away from zero, saturate
    function automatic logic signed [UV_W-1:0] rnd(logic signed [31:0] s, logic nz,
                                                   logic ovf, logic neg);
        logic signed [31:0] m, res;
        if (ovf)
            return neg ? 16'sh8000 : 16'sh7FFF;
        if (s >= 0)
            res = (s + 32'sd128) >>> 8;
        else
        begin
            m   = -s - $signed({31'd0, nz});
            res = -((m + 32'sd128) >>> 8);
        end
        if (res > 32'sd32767)
            return 16'sh7FFF;
        if (res < -32'sd32768)
            return 16'sh8000;
        return res[UV_W-1:0];
    endfunction

    // --------------------------------------------------------------- datapath
    always_comb
    begin
        item_t              it;
        logic [CAM_W-1:0]   mu, mv;
        logic [ZD_W+QK-1:0] du, dv;

        it = '0;
        it.kind    = points.data.kind;
        it.x       = points.data.point_x;
        it.y       = points.data.point_y;
        it.z       = points.data.point_z;
        it.prod[0] = tmul(row_x_reg[63:48], points.data.point_x);
        it.prod[1] = tmul(row_x_reg[47:32], points.data.point_y);
        it.prod[2] = tmul(row_x_reg[31:16], points.data.point_z);
        it.prod[3] = tmul(row_y_reg[63:48], points.data.point_x);
        it.prod[4] = tmul(row_y_reg[47:32], points.data.point_y);
        it.prod[5] = tmul(row_y_reg[31:16], points.data.point_z);
        it.prod[6] = tmul(row_z_reg[63:48], points.data.point_x);
        it.prod[7] = tmul(row_z_reg[47:32], points.data.point_y);
        it.prod[8] = tmul(row_z_reg[31:16], points.data.point_z);
        it.wr_ok   = (CW'(points.data.pixel_col) < cols_eff) &&
                     (RW'(points.data.pixel_row) < rows_eff);
        it.wr_bit  = points.data.gray > mask_thr_reg;
        it.addr    = ADDR_W'(32'(points.data.pixel_row) * MAX_MASK_COLS +
                             32'(points.data.pixel_col));
        it.status  = ST_STORED;
        pipe_next[0] = it;

        for (int i = 1; i < NSTG; i++)
            pipe_next[i] = pipe_reg[i-1];

        // camera coordinates
        it = pipe_reg[S_SUM-1];
        it.cx = rsum(it.prod[0], it.prod[1], it.prod[2], row_x_reg[15:0]);
        it.cy = rsum(it.prod[3], it.prod[4], it.prod[5], row_y_reg[15:0]);
        it.cz = rsum(it.prod[6], it.prod[7], it.prod[8], row_z_reg[15:0]);
        it.behind = it.cz <= 0;
        pipe_next[S_SUM] = it;

        // f * |num|, split in two slices
        it = pipe_reg[S_MUL-1];
        mu = it.cx[CAM_W-1] ? CAM_W'(-it.cx) : CAM_W'(it.cx);
        mv = it.cy[CAM_W-1] ? CAM_W'(-it.cy) : CAM_W'(it.cy);
        it.neg_u = it.cx[CAM_W-1];
        it.neg_v = it.cy[CAM_W-1];
        it.ml_u  = PP_W'(focal_reg[55:32]) * PP_W'(mu[MLO_W-1:0]);
        it.mh_u  = PP_W'(focal_reg[55:32]) * PP_W'(mu[ZD_W-1:MLO_W]);
        it.ml_v  = PP_W'(focal_reg[23:0]) * PP_W'(mv[MLO_W-1:0]);
        it.mh_v  = PP_W'(focal_reg[23:0]) * PP_W'(mv[ZD_W-1:MLO_W]);
        it.zd    = it.cz[ZD_W-1:0];
        pipe_next[S_MUL] = it;

        it = pipe_reg[S_ADD-1];
        it.a_u = (DIVN_W'(it.mh_u) << MLO_W) + DIVN_W'(it.ml_u);
        it.a_v = (DIVN_W'(it.mh_v) << MLO_W) + DIVN_W'(it.ml_v);
        pipe_next[S_ADD] = it;

        // quotient of more than QK bits saturates
        it = pipe_reg[S_OVF-1];
        it.ovf_u = (it.a_u >> QK) >= DIVN_W'(it.zd);
        it.ovf_v = (it.a_v >> QK) >= DIVN_W'(it.zd);
        it.r_u   = ZD_W'(it.a_u >> QK);
        it.r_v   = ZD_W'(it.a_v >> QK);
        it.q_u   = '0;
        it.q_v   = '0;
        pipe_next[S_OVF] = it;

        for (int j = 0; j < QK; j++)
        begin
            it = pipe_reg[S_DIV+j-1];
            du = dstep(it.r_u, it.q_u, it.a_u[QK-1-j], it.zd);
            dv = dstep(it.r_v, it.q_v, it.a_v[QK-1-j], it.zd);
            {it.r_u, it.q_u} = du;
            {it.r_v, it.q_v} = dv;
            pipe_next[S_DIV+j] = it;
        end

        it = pipe_reg[S_SC-1];
        it.nz_u = it.r_u != '0;
        it.nz_v = it.r_v != '0;
        it.s_u  = sfun(it.neg_u, it.q_u, it.r_u != '0, centre_reg[55:32]);
        it.s_v  = sfun(it.neg_v, it.q_v, it.r_v != '0, centre_reg[23:0]);
        pipe_next[S_SC] = it;

        it = pipe_reg[S_RND-1];
        it.pu = it.behind ? '0 : rnd(it.s_u, it.nz_u, it.ovf_u, it.neg_u);
        it.pv = it.behind ? '0 : rnd(it.s_v, it.nz_v, it.ovf_v, it.neg_v);
        pipe_next[S_RND] = it;

        it = pipe_reg[S_ADDR-1];
        it.need_rd = 1'b0;
        if (!it.kind)
        begin
            it.status = it.wr_ok ? ST_STORED : ST_OUTSIDE;
            it.pu = '0;
            it.pv = '0;
            it.x  = '0;
            it.y  = '0;
            it.z  = '0;
        end
        else if (it.behind)
            it.status = ST_BEHIND;
        else if (it.pu[UV_W-1] || it.pv[UV_W-1] ||
                 (UV_W'(it.pu) >= UV_W'(cols_eff)) || (UV_W'(it.pv) >= UV_W'(rows_eff)))
            it.status = ST_OUTSIDE;
        else
        begin
            it.status  = ST_MASK_OFF;
            it.need_rd = 1'b1;
            it.addr    = ADDR_W'(32'(it.pv) * MAX_MASK_COLS + 32'(it.pu));
        end
        pipe_next[S_ADDR] = it;

        // mask bit arrives from the RAM while the word sits in the hold stage
        it = pipe_reg[S_OUT-1];
        if (it.need_rd)
            it.status = ram_q ? ST_SELECTED : ST_MASK_OFF;
        pipe_next[S_OUT] = it;
    end

    // ------------------------------------------------------------------ flow
    assign en_all        = !valid_reg[S_OUT] || results.ready;
    assign ld0           = en_all || !valid_reg[0];
    assign points.ready  = ld0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ld0)
                valid_reg[0] <= points.valid;
            if (en_all)
                valid_reg[NSTG-1:1] <= valid_reg[NSTG-2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld0)
            pipe_reg[0] <= pipe_next[0];
        for (int i = 1; i < NSTG; i++)
        begin
            if (en_all)
                pipe_reg[i] <= pipe_next[i];
        end
    end

    assign ram_en = en_all && valid_reg[S_ADDR];

    lpmf_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_mask (
        .clk   (clk),
        .en    (ram_en),
        .we    (!pipe_reg[S_ADDR].kind && pipe_reg[S_ADDR].wr_ok),
        .addr  (pipe_reg[S_ADDR].addr),
        .wdata (pipe_reg[S_ADDR].wr_bit),
        .rdata (ram_q)
    );

    assign results.valid       = valid_reg[S_OUT];
    assign results.data.status = pipe_reg[S_OUT].status;
    assign results.data.pix_u  = pipe_reg[S_OUT].pu;
    assign results.data.pix_v  = pipe_reg[S_OUT].pv;
    assign results.data.out_x  = pipe_reg[S_OUT].x;
    assign results.data.out_y  = pipe_reg[S_OUT].y;
    assign results.data.out_z  = pipe_reg[S_OUT].z;

endmodule

>>> hdl/lpmf_checker.sv
// ============================================================================
// lpmf_checker - port checks for the point mask filter
// Watches the result channel and the form of result words.
// ============================================================================
module lpmf_checker
    import lpmf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result word changed while stalled");

    // mask writes carry no pixel and no point
    a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_STORED |->
            out_data.pix_u == 0 && out_data.pix_v == 0 &&
            out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0)
        else $error("mask write word not cleared");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_BEHIND |->
            out_data.pix_u == 0 && out_data.pix_v == 0)
        else $error("pixel set on point behind camera");

endmodule

bind lidar_point_mask_projection_filter_top lpmf_checker u_lpmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);
